[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Depends on nothing; each use expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GBA_ASSERT_IMPLY(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("gba check failed");

// next-cycle implication
`define GBA_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("gba check failed");

`endif

[rtl/gba_pkg.sv]
// Package for the grouped bitmap allocator: sizes, codes, word and state types.
// Depends on nothing; imported by the allocator, its checker and the bench.
package gba_pkg;

   localparam int GROUP_BITS      = 8192;
   localparam int MAX_GROUPS      = 16;
   localparam int WORD_BITS       = 32;

   localparam int WORDS_PER_GROUP = (GROUP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int MEM_DEPTH       = MAX_GROUPS * WORDS_PER_GROUP;
   localparam int GRP_AW          = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int WORD_AW         = (WORDS_PER_GROUP > 1) ? $clog2(WORDS_PER_GROUP) : 1;
   localparam int MEM_AW          = GRP_AW + WORD_AW;
   localparam int BIT_AW          = $clog2(WORD_BITS);
   localparam int GRP_CNT_W       = GRP_AW + 1;
   localparam int NWORD_W         = WORD_AW + 1;

   localparam int NUM_W           = 18;
   localparam int GC_W            = 5;
   localparam int PG_W            = 14;
   localparam int STAT_W          = 2;
   localparam int CSR_AW          = 4;
   localparam int CSR_DW          = 32;

   localparam logic [GC_W-1:0] GC_RESET = GC_W'(16);
   localparam logic [PG_W-1:0] PG_RESET = PG_W'(8192);
   localparam logic            NB_RESET = 1'b0;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;

   localparam logic [1:0] CSR_GROUP_COUNT = 2'd0;
   localparam logic [1:0] CSR_PER_GROUP   = 2'd1;
   localparam logic [1:0] CSR_NUMBER_BASE = 2'd2;

   typedef struct packed {
      logic             req_type;
      logic [NUM_W-1:0] object_number;
   } req_word_type;

   typedef struct packed {
      logic [NUM_W-1:0]  allocated_number;
      logic [STAT_W-1:0] status;
   } rsp_word_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DIV,
      S_CLR_BIT,
      S_DONE
   } gba_state_type;

endpackage

[rtl/grouped_bitmap_allocator.sv]
// Allocate: scans bitmap words in order, up to 4096 words, for the first free bit; no scan with no objects.
// Free: splits the number into group and index by repeated subtraction of the per-group count.
// One request in flight at a time; the next is taken once the result is in the output register.
// Reset (synchronous): a clearing pass writes all 4096 bitmap words to free,
// with req_stall high; configuration registers return to 16 groups, 8192 per group, base 0.
module grouped_bitmap_allocator
   import gba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_word_type        req_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_word_type        rsp_word,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [CSR_DW-1:0]   pwdata,
   output logic [CSR_DW-1:0]   prdata,
   output logic                pready
);

   gba_state_type state_ff, state_in;

   logic [GC_W-1:0]      gc_ff;
   logic [PG_W-1:0]      pg_ff;
   logic                 base_ff;

   logic [MEM_AW-1:0]    clr_ff, clr_in;
   logic [GRP_CNT_W-1:0] ig_ff, ig_in;
   logic [WORD_AW-1:0]   iw_ff, iw_in;
   logic [NUM_W-1:0]     ioff_ff, ioff_in;
   logic                 iss_ff, iss_in;
   logic                 ev_ff, ev_in;
   logic [GRP_AW-1:0]    eg_ff, eg_in;
   logic [WORD_AW-1:0]   ew_ff, ew_in;
   logic [NUM_W-1:0]     eoff_ff, eoff_in;
   logic [NUM_W-1:0]     rem_ff, rem_in;
   logic [GRP_CNT_W-1:0] quo_ff, quo_in;
   logic [NUM_W-1:0]     res_num_ff, res_num_in;
   logic [STAT_W-1:0]    res_st_ff, res_st_in;
   logic                 rsp_valid_ff;
   rsp_word_type         rsp_word_ff;

   logic                 mem_we;
   logic [MEM_AW-1:0]    mem_waddr, mem_raddr;
   logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

   logic [GRP_CNT_W-1:0] gc_eff;
   logic [PG_W-1:0]      nb;
   logic [PG_W:0]        nb_round;
   logic [NWORD_W-1:0]   nwords, full_words;
   logic [WORD_BITS-1:0] word_mask, clear_bits;
   logic [BIT_AW-1:0]    hit_bit;
   logic                 req_acc, scan_hit, scan_dry, div_ge, div_over, idx_big;
   logic                 free_bad, alloc_empty, rsp_free, csr_wr;

   gba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // effective sizes
   assign gc_eff     = (int'(gc_ff) > MAX_GROUPS) ? GRP_CNT_W'(MAX_GROUPS) : GRP_CNT_W'(gc_ff);
   assign nb         = (int'(pg_ff) > GROUP_BITS) ? PG_W'(GROUP_BITS) : pg_ff;
   assign nb_round   = {1'b0, nb} + (PG_W+1)'(WORD_BITS - 1);
   assign nwords     = NWORD_W'(nb_round >> BIT_AW);
   assign full_words = NWORD_W'(nb >> BIT_AW);

   assign word_mask  = ({1'b0, ew_ff} < full_words) ? {WORD_BITS{1'b1}}
                     : ((WORD_BITS'(1) << nb[BIT_AW-1:0]) - WORD_BITS'(1));
   assign clear_bits = ~mem_rdata & word_mask;

   always_comb begin
      hit_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (clear_bits[i]) begin
            hit_bit = BIT_AW'(i);
         end
      end
   end

   assign req_acc     = req_valid && !req_stall;
   assign req_stall   = (state_ff != S_IDLE);
   assign scan_hit    = ev_ff && (clear_bits != '0);
   assign scan_dry    = !iss_ff && !scan_hit;
   assign div_ge      = (rem_ff >= NUM_W'(pg_ff));
   assign div_over    = ((quo_ff + GRP_CNT_W'(1)) >= gc_eff);
   assign idx_big     = (rem_ff >= NUM_W'(GROUP_BITS));
   assign free_bad    = (req_word.object_number < NUM_W'(base_ff)) || (pg_ff == '0)
                     || (gc_eff == '0);
   assign alloc_empty = (gc_eff == '0) || (nb == '0);
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == MEM_AW'(MEM_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               if (req_word.req_type == REQ_FREE) begin
                  state_in = free_bad ? S_DONE : S_DIV;
               end else begin
                  state_in = alloc_empty ? S_DONE : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_hit || scan_dry) begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            if (div_ge) begin
               if (div_over) begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = idx_big ? S_DONE : S_CLR_BIT;
            end
         end
         S_CLR_BIT: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      clr_in     = clr_ff;
      ig_in      = ig_ff;
      iw_in      = iw_ff;
      ioff_in    = ioff_ff;
      iss_in     = iss_ff;
      ev_in      = 1'b0;
      eg_in      = eg_ff;
      ew_in      = ew_ff;
      eoff_in    = eoff_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      res_num_in = res_num_ff;
      res_st_in  = res_st_ff;
      mem_we     = 1'b0;
      mem_waddr  = clr_ff;
      mem_wdata  = '0;
      mem_raddr  = {ig_ff[GRP_AW-1:0], iw_ff};
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + MEM_AW'(1);
         end
         S_IDLE: begin
            if (req_acc) begin
               res_num_in = '0;
               if (req_word.req_type == REQ_FREE) begin
                  res_st_in = STAT_RANGE;
                  rem_in    = req_word.object_number - NUM_W'(base_ff);
                  quo_in    = '0;
               end else begin
                  res_st_in = STAT_NO_SPACE;
                  ig_in     = '0;
                  iw_in     = '0;
                  ioff_in   = '0;
                  iss_in    = !alloc_empty;
               end
            end
         end
         S_SCAN: begin
            if (iss_ff) begin
               ev_in   = 1'b1;
               eg_in   = ig_ff[GRP_AW-1:0];
               ew_in   = iw_ff;
               eoff_in = ioff_ff;
               if (({1'b0, iw_ff} + NWORD_W'(1)) == nwords) begin
                  iw_in   = '0;
                  ig_in   = ig_ff + GRP_CNT_W'(1);
                  ioff_in = ioff_ff + NUM_W'(pg_ff);
                  if ((ig_ff + GRP_CNT_W'(1)) == gc_eff) begin
                     iss_in = 1'b0;
                  end
               end else begin
                  iw_in = iw_ff + WORD_AW'(1);
               end
            end
            if (scan_hit) begin
               mem_we     = 1'b1;
               mem_waddr  = {eg_ff, ew_ff};
               mem_wdata  = mem_rdata | (WORD_BITS'(1) << hit_bit);
               res_num_in = eoff_ff + NUM_W'({ew_ff, {BIT_AW{1'b0}}}) + NUM_W'(hit_bit)
                          + NUM_W'(base_ff);
               res_st_in  = STAT_OK;
               iss_in     = 1'b0;
               ev_in      = 1'b0;
            end
         end
         S_DIV: begin
            mem_raddr = {quo_ff[GRP_AW-1:0], rem_ff[BIT_AW +: WORD_AW]};
            if (div_ge && !div_over) begin
               rem_in = rem_ff - NUM_W'(pg_ff);
               quo_in = quo_ff + GRP_CNT_W'(1);
            end
         end
         S_CLR_BIT: begin
            mem_we    = 1'b1;
            mem_waddr = {quo_ff[GRP_AW-1:0], rem_ff[BIT_AW +: WORD_AW]};
            mem_wdata = mem_rdata & ~(WORD_BITS'(1) << rem_ff[BIT_AW-1:0]);
            res_st_in = STAT_OK;
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         iss_ff       <= 1'b0;
         ev_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         iss_ff   <= iss_in;
         ev_ff    <= ev_in;
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ig_ff      <= ig_in;
      iw_ff      <= iw_in;
      ioff_ff    <= ioff_in;
      eg_ff      <= eg_in;
      ew_ff      <= ew_in;
      eoff_ff    <= eoff_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      res_num_ff <= res_num_in;
      res_st_ff  <= res_st_in;
      if (state_ff == S_DONE && rsp_free) begin
         rsp_word_ff.allocated_number <= res_num_ff;
         rsp_word_ff.status           <= res_st_ff;
      end
   end

   // configuration registers
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gc_ff   <= GC_RESET;
         pg_ff   <= PG_RESET;
         base_ff <= NB_RESET;
      end else if (csr_wr) begin
         case (paddr[3:2])
            CSR_GROUP_COUNT: gc_ff   <= pwdata[GC_W-1:0];
            CSR_PER_GROUP:   pg_ff   <= pwdata[PG_W-1:0];
            CSR_NUMBER_BASE: base_ff <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         CSR_GROUP_COUNT: prdata = CSR_DW'(gc_ff);
         CSR_PER_GROUP:   prdata = CSR_DW'(pg_ff);
         CSR_NUMBER_BASE: prdata = CSR_DW'(base_ff);
         default:         prdata = '0;
      endcase
   end

   assign pready    = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[rtl/gba_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module gba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/gba_checker.sv]
// Port-level checker for the grouped bitmap allocator, bound to the top level.
// Depends on gba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gba_checker
   import gba_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   logic rsp_failed;

   assign rsp_failed = rsp_valid && (rsp_word.status != STAT_OK);

   `GBA_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && req_stall)
   `GBA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)
   `GBA_ASSERT_IMPLY(a_fail_number_zero, clock, reset, rsp_failed, rsp_word.allocated_number == '0)
   `GBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

endmodule

bind grouped_bitmap_allocator gba_checker u_gba_checker (.*);

[bench/tb_top.sv]
// Self-checking bench for grouped_bitmap_allocator: directed and random alloc/free words,
// register setups across the field extremes, random stalls on both channels.
// Depends on gba_pkg and the allocator RTL only.
module tb_top
   import gba_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;
   localparam int MAX_NUMBER = (1 << NUM_W) - 1;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_word_type        req_word;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_word_type        rsp_word;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [CSR_DW-1:0]   pwdata;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   grouped_bitmap_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // shadow of the block: usage bits and register copies
   bit                usage_map [MAX_GROUPS][GROUP_BITS];
   logic [GC_W-1:0]   cfg_groups    = GC_RESET;
   logic [PG_W-1:0]   cfg_per_group = PG_RESET;
   logic              cfg_base      = NB_RESET;

   rsp_word_type      expected_answers [$];
   int unsigned       held_numbers [$];
   int                error_count     = 0;
   int                idle_cycles     = 0;
   int                rsp_hold_cycles = 0;
   bit                sender_gaps     = 1'b0;
   bit                receiver_gaps   = 1'b0;

   function automatic int unsigned groups_active();
      return (cfg_groups > MAX_GROUPS) ? MAX_GROUPS : cfg_groups;
   endfunction

   function automatic rsp_word_type predict_allocation(input req_word_type w);
      rsp_word_type r;
      int unsigned  gc;
      int unsigned  nb;
      int unsigned  rel;
      int unsigned  grp;
      int unsigned  idx;
      bit           found;
      gc = groups_active();
      nb = (cfg_per_group > GROUP_BITS) ? GROUP_BITS : cfg_per_group;
      r.allocated_number = '0;
      r.status = STAT_OK;
      if (w.req_type == REQ_ALLOC) begin
         found = 1'b0;
         for (int g = 0; g < gc && !found; g++) begin
            for (int i = 0; i < nb && !found; i++) begin
               if (!usage_map[g][i]) begin
                  usage_map[g][i] = 1'b1;
                  r.allocated_number = NUM_W'(g * cfg_per_group + i + cfg_base);
                  found = 1'b1;
               end
            end
         end
         if (!found)
            r.status = STAT_NO_SPACE;
      end else if (w.object_number < cfg_base || cfg_per_group == 0) begin
         r.status = STAT_RANGE;
      end else begin
         rel = w.object_number - cfg_base;
         grp = rel / cfg_per_group;
         idx = rel % cfg_per_group;
         if (grp >= gc || idx >= GROUP_BITS)
            r.status = STAT_RANGE;
         else
            usage_map[grp][idx] = 1'b0;
      end
      return r;
   endfunction

   // sender: one word, random gap first, held until accepted
   task automatic send_word(input req_word_type w);
      int           gap;
      rsp_word_type r;
      gap = sender_gaps ? $urandom_range(18, 0) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  = w;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = predict_allocation(w);
      expected_answers.push_back(r);
      if (w.req_type == REQ_ALLOC && r.status == STAT_OK)
         held_numbers.push_back(32'(r.allocated_number));
   endtask

   task automatic send_alloc();
      req_word_type w;
      w.req_type      = REQ_ALLOC;
      w.object_number = NUM_W'($urandom);
      send_word(w);
   endtask

   task automatic send_free(input int unsigned number);
      req_word_type w;
      w.req_type      = REQ_FREE;
      w.object_number = NUM_W'(number);
      send_word(w);
   endtask

   task automatic send_random_word();
      int          pick;
      int          k;
      int unsigned span;
      pick = $urandom_range(99, 0);
      if (pick < 55) begin
         send_alloc();
      end else if (pick < 85 && held_numbers.size() > 0) begin
         k = $urandom_range(held_numbers.size() - 1, 0);
         send_free(held_numbers[k]);
         held_numbers.delete(k);
      end else if (pick < 95) begin
         span = groups_active() * cfg_per_group;
         if (span > 0)
            send_free(cfg_base + $urandom_range(span - 1, 0));
         else
            send_free($urandom_range(MAX_NUMBER, 0));
      end else begin
         send_free($urandom_range(MAX_NUMBER, 0));
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] field_mask;
      logic [CSR_DW-1:0] readback;
      case (index)
         CSR_GROUP_COUNT: field_mask = (1 << GC_W) - 1;
         CSR_PER_GROUP:   field_mask = (1 << PG_W) - 1;
         default:         field_mask = 1;
      endcase
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CSR_AW'({index, 2'b00});
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      readback = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      case (index)
         CSR_GROUP_COUNT: cfg_groups    = value[GC_W-1:0];
         CSR_PER_GROUP:   cfg_per_group = value[PG_W-1:0];
         default:         cfg_base      = value[0];
      endcase
      if (readback !== (value & field_mask)) begin
         $display("%0t register %0d readback: expected %0h actual %0h",
                  $time, index, value & field_mask, readback);
         error_count++;
      end
   endtask

   // junk above each field checks that only the field bits are kept
   task automatic set_config(input int unsigned gc, input int unsigned pg, input int unsigned nb);
      drain_results();
      write_register(CSR_GROUP_COUNT, ($urandom << GC_W) | gc);
      write_register(CSR_PER_GROUP, ($urandom << PG_W) | pg);
      write_register(CSR_NUMBER_BASE, ($urandom << 1) | nb);
      held_numbers.delete();
   endtask

   task automatic test_reset_defaults();
      repeat (4) send_alloc();
      send_free(1);
      send_free(1);
      send_alloc();
      send_free(0);
      send_free(GROUP_BITS * MAX_GROUPS - 1);
      send_free(GROUP_BITS * MAX_GROUPS);
      send_free(MAX_NUMBER);
      send_free(18'h2AAAA);
      send_free(18'h15555);
      send_alloc();
   endtask

   task automatic test_empty_store();
      set_config(0, 8192, 0);
      send_alloc();
      send_free(5);
      set_config(16, 0, 0);
      send_alloc();
      send_free(0);
   endtask

   task automatic test_wide_config();
      set_config(31, 16383, 1);
      send_free(0);
      send_alloc();
      send_free(1 + 9000);
      send_free(1 + 16383 * 15 + 5);
      send_free(1 + 16383 * 16);
      send_alloc();
   endtask

   task automatic test_no_space();
      set_config(1, 1, 1);
      send_alloc();
      send_free(1);
      send_alloc();
      send_alloc();
      send_free(2);
      send_free(0);
   endtask

   task automatic test_random_phases();
      int unsigned gc;
      int unsigned pg;
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(3, 0))
            0: begin gc = $urandom_range(3, 1);   pg = $urandom_range(12, 1);       end
            1: begin gc = $urandom_range(16, 1);  pg = $urandom_range(200, 1);      end
            2: begin gc = $urandom_range(31, 16); pg = $urandom_range(16383, 8000); end
            default: begin gc = 16; pg = 8192; end
         endcase
         set_config(gc, pg, $urandom_range(1, 0));
         sender_gaps   = 1'($urandom_range(1, 0));
         receiver_gaps = 1'($urandom_range(1, 0));
         repeat (15) send_random_word();
      end
   endtask

   task automatic test_output_backpressure();
      set_config(2, 20, 0);
      sender_gaps     = 1'b0;
      receiver_gaps   = 1'b1;
      rsp_hold_cycles = 250;
      repeat (10) send_random_word();
   endtask

   // result side: random stall per word, then check against the oldest expectation
   initial begin
      rsp_word_type want;
      int           hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         hold = receiver_gaps ? $urandom_range(18, 0) : 0;
         if (rsp_hold_cycles != 0) begin
            hold = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (hold != 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (expected_answers.size() == 0) begin
            $display("%0t unexpected result word: number %0d status %0d",
                     $time, rsp_word.allocated_number, rsp_word.status);
            error_count++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_word.allocated_number !== want.allocated_number) begin
               $display("%0t allocated_number: expected %0d actual %0d",
                        $time, want.allocated_number, rsp_word.allocated_number);
               error_count++;
            end
            if (rsp_word.status !== want.status) begin
               $display("%0t status: expected %0d actual %0d",
                        $time, want.status, rsp_word.status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_empty_store();
      test_wide_config();
      test_no_space();
      test_random_phases();
      test_output_backpressure();
      drain_results();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/gba_pkg.sv
rtl/gba_ram.sv
rtl/grouped_bitmap_allocator.sv
rtl/gba_checker.sv
bench/tb_top.sv
